>>> hw/rtl/lcar_pkg.sv
package lcar_pkg;

   localparam int ACTION_W     = 2;
   localparam int COUNT_W      = 7;
   localparam int COUNT_CMP_W  = 9;
   localparam int GAIN_W       = 2;
   localparam int VALUE_W      = 25;
   localparam int VALUE_LIMIT  = 16777215;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [ACTION_W-1:0] ACTION_MEASURE = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_TARE    = 2'd2;

   localparam logic CSR_REG_GAIN = 1'b0;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WAIT,
      S_BIT_HI,
      S_BIT_LO,
      S_PULSE_HI,
      S_PULSE_LO,
      S_DIV_LOAD,
      S_DIV_RUN,
      S_DIV_SIGN,
      S_FINISH
   } lcar_state_type;

   typedef struct packed {
      logic start_req;
      logic start_sample;
      logic shift_bit;
      logic clear_pulse;
      logic inc_pulse;
      logic accumulate;
      logic div_load;
      logic div_step;
      logic div_sign;
      logic finish;
      logic load_rsp;
      logic rsp_sck;
      logic rsp_busy;
   } lcar_cmd_type;

   typedef struct packed {
      logic bits_last;
      logic pulse_more;
      logic samples_last;
      logic div_last;
   } lcar_status_type;

endpackage

>>> hw/rtl/lcar_ctrl.sv
module lcar_ctrl
   import lcar_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_dout_level,
   input  logic [ACTION_W-1:0] req_action,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  lcar_status_type     status,
   output lcar_cmd_type        cmd
);

   lcar_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;
   logic           seq_phase;
   logic           accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign seq_phase = (state_ff == S_IDLE) || (state_ff == S_WAIT) ||
                      (state_ff == S_BIT_HI) || (state_ff == S_BIT_LO) ||
                      (state_ff == S_PULSE_HI) || (state_ff == S_PULSE_LO);
   assign req_ready = seq_phase && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         cmd.load_rsp = 1'b1;
         rsp_valid_in = 1'b1;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_action == ACTION_MEASURE || req_action == ACTION_TARE)) begin
               cmd.start_req = 1'b1;
               state_in      = S_WAIT;
            end
         end
         S_WAIT: begin
            if (accept && !req_dout_level) begin
               cmd.start_sample = 1'b1;
               state_in         = S_BIT_HI;
            end
         end
         S_BIT_HI: begin
            cmd.rsp_sck = 1'b1;
            if (accept) begin
               state_in = S_BIT_LO;
            end
         end
         S_BIT_LO: begin
            if (accept) begin
               cmd.shift_bit = 1'b1;
               if (status.bits_last) begin
                  cmd.clear_pulse = 1'b1;
                  state_in        = S_PULSE_HI;
               end else begin
                  state_in = S_BIT_HI;
               end
            end
         end
         S_PULSE_HI: begin
            cmd.rsp_sck = 1'b1;
            if (accept) begin
               state_in = S_PULSE_LO;
            end
         end
         S_PULSE_LO: begin
            if (accept) begin
               if (status.pulse_more) begin
                  cmd.inc_pulse = 1'b1;
                  state_in      = S_PULSE_HI;
               end else begin
                  cmd.accumulate = 1'b1;
                  if (status.samples_last) begin
                     // result goes out after the divide
                     cmd.load_rsp = 1'b0;
                     rsp_valid_in = rsp_valid_ff && !rsp_ready;
                     state_in     = S_DIV_LOAD;
                  end else begin
                     state_in = S_WAIT;
                  end
               end
            end
         end
         S_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = S_DIV_RUN;
         end
         S_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_DIV_SIGN;
            end
         end
         S_DIV_SIGN: begin
            cmd.div_sign = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      cmd.rsp_busy = (state_in != S_IDLE);
   end

endmodule

>>> hw/rtl/lcar_dp.sv
module lcar_dp
   import lcar_pkg::*;
#(
   parameter int SAMPLE_BITS = 24,
   parameter int MAX_SAMPLES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lcar_cmd_type              cmd,
   output lcar_status_type           status,
   input  logic                      req_dout_level,
   input  logic [ACTION_W-1:0]       req_action,
   input  logic [COUNT_W-1:0]        req_sample_count,
   input  logic [GAIN_W-1:0]         gain_pulses,
   output logic                      rsp_sck_level,
   output logic                      rsp_busy_res,
   output logic                      rsp_result_valid,
   output logic                      rsp_result_kind,
   output logic signed [VALUE_W-1:0] rsp_value
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = SAMPLE_BITS + CNT_W;
   localparam int BCW   = $clog2(SAMPLE_BITS);
   localparam int DCW   = $clog2(SUM_W);
   localparam int VW    = (SAMPLE_BITS + 1 > VALUE_W + 1) ? SAMPLE_BITS + 1 : VALUE_W + 1;
   localparam logic signed [VW-1:0] VLIM = VW'(VALUE_LIMIT);

   logic [BCW-1:0]                bit_cnt_ff, bit_cnt_in;
   logic [GAIN_W-1:0]             pulse_cnt_ff, pulse_cnt_in;
   logic [SAMPLE_BITS-1:0]        shift_ff, shift_in;
   logic [CNT_W-1:0]              done_ff, done_in;
   logic [CNT_W-1:0]              wanted_ff, wanted_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0] offset_ff, offset_in;
   logic                          tare_ff, tare_in;
   logic [SUM_W-1:0]              quo_ff, quo_in;
   logic [CNT_W-1:0]              rem_ff, rem_in;
   logic [DCW-1:0]                div_cnt_ff, div_cnt_in;
   logic                          neg_ff, neg_in;
   logic signed [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic                          sck_ff, busy_ff, fin_ff, kind_ff;
   logic signed [VALUE_W-1:0]     value_ff;

   logic [COUNT_CMP_W-1:0]        count_wide;
   logic [CNT_W:0]                trial;
   logic [CNT_W:0]                trial_sub;
   logic signed [VW-1:0]          mean_x;
   logic signed [VW-1:0]          res_x;
   logic signed [VW-1:0]          res_sat;

   assign count_wide = COUNT_CMP_W'(req_sample_count);
   assign trial      = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_sub  = trial - {1'b0, wanted_ff};
   assign mean_x     = VW'(mean_ff);
   assign res_x      = tare_ff ? mean_x : mean_x - VW'(offset_ff);

   always_comb begin
      priority if (res_x > VLIM) begin
         res_sat = VLIM;
      end else if (res_x < -VLIM) begin
         res_sat = -VLIM;
      end else begin
         res_sat = res_x;
      end
   end

   assign status.bits_last    = (bit_cnt_ff == BCW'(SAMPLE_BITS - 1));
   assign status.pulse_more   = (pulse_cnt_ff < gain_pulses);
   assign status.samples_last = (CNT_W'(done_ff + 1'b1) == wanted_ff);
   assign status.div_last     = (div_cnt_ff == DCW'(SUM_W - 1));

   always_comb begin
      bit_cnt_in   = bit_cnt_ff;
      pulse_cnt_in = pulse_cnt_ff;
      shift_in     = shift_ff;
      done_in      = done_ff;
      wanted_in    = wanted_ff;
      sum_in       = sum_ff;
      offset_in    = offset_ff;
      tare_in      = tare_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      neg_in       = neg_ff;
      mean_in      = mean_ff;
      if (cmd.start_req) begin
         priority if (count_wide == '0) begin
            wanted_in = CNT_W'(1);
         end else if (count_wide > COUNT_CMP_W'(MAX_SAMPLES)) begin
            wanted_in = CNT_W'(MAX_SAMPLES);
         end else begin
            wanted_in = CNT_W'(count_wide);
         end
         done_in = '0;
         sum_in  = '0;
         tare_in = (req_action == ACTION_TARE);
      end
      if (cmd.start_sample) begin
         bit_cnt_in = '0;
         shift_in   = '0;
      end
      if (cmd.shift_bit) begin
         shift_in   = {shift_ff[SAMPLE_BITS-2:0], req_dout_level};
         bit_cnt_in = bit_cnt_ff + 1'b1;
      end
      if (cmd.clear_pulse) begin
         pulse_cnt_in = '0;
      end
      if (cmd.inc_pulse) begin
         pulse_cnt_in = pulse_cnt_ff + 1'b1;
      end
      if (cmd.accumulate) begin
         sum_in  = sum_ff + SUM_W'($signed(shift_ff));
         done_in = done_ff + 1'b1;
      end
      if (cmd.div_load) begin
         neg_in     = sum_ff[SUM_W-1];
         quo_in     = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
         rem_in     = '0;
         div_cnt_in = '0;
      end
      if (cmd.div_step) begin
         if (!trial_sub[CNT_W]) begin
            rem_in = trial_sub[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         div_cnt_in = div_cnt_ff + 1'b1;
      end
      if (cmd.div_sign) begin
         mean_in = neg_ff ? SAMPLE_BITS'(-quo_ff) : SAMPLE_BITS'(quo_ff);
      end
      if (cmd.finish && tare_ff) begin
         offset_in = mean_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_cnt_ff   <= bit_cnt_in;
      pulse_cnt_ff <= pulse_cnt_in;
      shift_ff     <= shift_in;
      done_ff      <= done_in;
      wanted_ff    <= wanted_in;
      sum_ff       <= sum_in;
      tare_ff      <= tare_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      div_cnt_ff   <= div_cnt_in;
      neg_ff       <= neg_in;
      mean_ff      <= mean_in;
      if (cmd.load_rsp) begin
         sck_ff   <= cmd.rsp_sck;
         busy_ff  <= cmd.rsp_busy;
         fin_ff   <= cmd.finish;
         kind_ff  <= cmd.finish && tare_ff;
         value_ff <= cmd.finish ? res_sat[VALUE_W-1:0] : '0;
      end
   end

   assign rsp_sck_level    = sck_ff;
   assign rsp_busy_res     = busy_ff;
   assign rsp_result_valid = fin_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_value        = value_ff;

endmodule

>>> hw/rtl/load_cell_adc_serial_reader.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  dout_level, action, sample_count
// rsp       out        rsp_valid / rsp_ready  sck_level, busy_res, result_valid,
//                                             result_kind, value
// csr       in         apb psel/penable       gain_pulses at byte address 0
//
// one transaction per cycle for every serial clock phase, while rsp is not stalled
// the phase that completes a request goes through divider load, the shift-subtract divider
//    at one quotient bit a cycle, sign fix and finish before its result goes out
// synchronous active-high reset: idle, no result pending, tare offset zero
// a stalled rsp holds its register; req is taken while it drains in the same cycle
module load_cell_adc_serial_reader
   import lcar_pkg::*;
#(
   parameter int SAMPLE_BITS = 24,
   parameter int MAX_SAMPLES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_dout_level,
   input  logic [ACTION_W-1:0]       req_action,
   input  logic [COUNT_W-1:0]        req_sample_count,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_sck_level,
   output logic                      rsp_busy_res,
   output logic                      rsp_result_valid,
   output logic                      rsp_result_kind,
   output logic signed [VALUE_W-1:0] rsp_value,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   output logic [CSR_DATA_W-1:0]     prdata,
   output logic                      pready
);

   logic [GAIN_W-1:0] gain_ff, gain_in;
   lcar_cmd_type      cmd;
   lcar_status_type   status;

   assign pready = 1'b1;

   always_comb begin
      gain_in = gain_ff;
      if (psel && penable && pwrite && (paddr[CSR_ADDR_W-1] == CSR_REG_GAIN)) begin
         gain_in = pwdata[GAIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
      end else begin
         gain_ff <= gain_in;
      end
   end

   assign prdata = (paddr[CSR_ADDR_W-1] == CSR_REG_GAIN) ? CSR_DATA_W'(gain_ff) : '0;

   lcar_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_dout_level (req_dout_level),
      .req_action     (req_action),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .status         (status),
      .cmd            (cmd)
   );

   lcar_dp #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_dout_level   (req_dout_level),
      .req_action       (req_action),
      .req_sample_count (req_sample_count),
      .gain_pulses      (gain_ff),
      .rsp_sck_level    (rsp_sck_level),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_result_valid (rsp_result_valid),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_value        (rsp_value)
   );

endmodule

>>> hw/rtl/lcar_checker.sv
module lcar_checker
   import lcar_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_sck_level,
   input logic                      rsp_busy_res,
   input logic                      rsp_result_valid,
   input logic                      rsp_result_kind,
   input logic signed [VALUE_W-1:0] rsp_value
);

   // stalled transaction stays valid and holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("rsp transaction changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_valid |-> !rsp_busy_res && !rsp_sck_level)
      else $error("completion while busy or with clock high");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_valid |-> rsp_value == '0 && !rsp_result_kind)
      else $error("result fields set without completion");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sck_level |-> rsp_busy_res)
      else $error("serial clock high outside a request");

endmodule

bind load_cell_adc_serial_reader lcar_checker u_checker (.*);
